// ----- design/pwm_duty_ramp_generator_assert.svh -----
// Assertion macros for the duty ramp generator.
// Each macro expects clk and rst_n in the scope that uses it.
`ifndef PWM_DUTY_RAMP_GENERATOR_ASSERT_SVH
`define PWM_DUTY_RAMP_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset only
`define PDR_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pdr: same-cycle check failed");

// Next-cycle implication, checked out of reset only
`define PDR_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pdr: next-cycle check failed");

`endif

// ----- design/pdr_pkg.sv -----
// Shared types, widths and helper functions for the duty ramp generator.
// No dependencies; the interfaces, the divider and the top module import it.
package pdr_pkg;

    // Internal duty resolution: 1.0 = 2^DUTY_FRACTION_BITS
    localparam int DUTY_FRACTION_BITS = 23;
    localparam int PORT_FRACTION_BITS = 15;
    localparam int PORT_W             = PORT_FRACTION_BITS + 2;
    localparam int DUTY_W             = DUTY_FRACTION_BITS + 1;
    localparam int ACC_W              = DUTY_FRACTION_BITS + 3;
    localparam int CFG_W              = 16;
    localparam int SEG_W              = 16;
    localparam int CMP_W              = 16;
    localparam int MUL_W              = DUTY_W + CFG_W;
    localparam int DIV_STEPS          = DUTY_W;
    localparam int DIV_CNT_W          = $clog2(DIV_STEPS);
    localparam int PORT_SHIFT         = DUTY_FRACTION_BITS - PORT_FRACTION_BITS;

    typedef logic        [DUTY_W-1:0] duty_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [PORT_W-1:0] port_duty_t;
    typedef logic        [SEG_W-1:0]  seg_t;

    localparam duty_t DUTY_ONE = {1'b1, {DUTY_FRACTION_BITS{1'b0}}};

    // Configuration register indexes
    localparam logic REG_PERIOD          = 1'b0;
    localparam logic REG_SEGMENT_SAMPLES = 1'b1;

    // Command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Q15 port value to clamped internal duty
    function automatic duty_t port_to_duty(port_duty_t v);
        duty_t r;
        if (v[PORT_W-1]) begin
            r = '0;
        end
        else if (v[PORT_W-2:0] > {1'b1, {PORT_FRACTION_BITS{1'b0}}}) begin
            r = DUTY_ONE;
        end
        else begin
            r = duty_t'(v[PORT_W-2:0]) << PORT_SHIFT;
        end
        return r;
    endfunction

    // Clamp accumulator to 0..1.0
    function automatic duty_t clamp_acc(acc_t a);
        duty_t r;
        if (a[ACC_W-1]) begin
            r = '0;
        end
        else if (a > acc_t'(DUTY_ONE)) begin
            r = DUTY_ONE;
        end
        else begin
            r = a[DUTY_W-1:0];
        end
        return r;
    endfunction

    // Saturating accumulator add
    function automatic acc_t sat_add(acc_t a, acc_t b);
        logic signed [ACC_W:0] s;
        acc_t r;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else begin
            r = s[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- design/pdr_item_if.sv -----
// Input word channel of the duty ramp generator.
// Depends on pdr_pkg for field widths.
interface pdr_item_if
    import pdr_pkg::*;
    ();
    logic       valid;
    logic       ready;
    logic       command;
    port_duty_t initial_duty;
    logic       target_valid;
    port_duty_t target_duty;

    modport source (output valid, command, initial_duty, target_valid, target_duty,
                    input ready);
    modport sink   (input valid, command, initial_duty, target_valid, target_duty,
                    output ready);
endinterface

// ----- design/pdr_result_if.sv -----
// Result word channel of the duty ramp generator.
// Depends on pdr_pkg for field widths.
interface pdr_result_if
    import pdr_pkg::*;
    ();
    logic             valid;
    logic             ready;
    logic [CMP_W-1:0] compare_value;
    logic             segment_began;

    modport source (output valid, compare_value, segment_began, input ready);
    modport sink   (input valid, compare_value, segment_began, output ready);
endinterface

// ----- design/pdr_divider.sv -----
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// Depends on pdr_pkg for operand widths and step count.
module pdr_divider
    import pdr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  duty_t       dividend,
    input  seg_t        divisor,
    output logic        done,
    output duty_t       quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    duty_t                quo_reg;
    seg_t                 rem_reg;
    seg_t                 div_reg;
    logic [SEG_W:0]       shifted;
    logic                 fits;

    // Bring down the next dividend bit and trial-subtract
    assign shifted = {rem_reg, quo_reg[DUTY_W-1]};
    assign fits    = shifted >= {1'b0, div_reg};

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Partial remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? seg_t'(shifted - {1'b0, div_reg}) : shifted[SEG_W-1:0];
            quo_reg <= {quo_reg[DUTY_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- design/pwm_duty_ramp_generator.sv -----
// Linear duty ramp generator: one PWM compare value per input word. A start word
// goes through prep, divide, multiply and finish; a tick skips divide unless it
// opens a new segment, the serial divider then setting the time spent there (one
// quotient bit per cycle, DUTY_FRACTION_BITS+1 bits). One word is in work at a
// time; a finished result waits in the output register while the next word is taken.
// Depends on pdr_pkg, pdr_item_if, pdr_result_if, pdr_divider and the assert header.
`include "pwm_duty_ramp_generator_assert.svh"

module pwm_duty_ramp_generator
    import pdr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    pdr_item_if.sink         item,
    pdr_result_if.source     result,
    input  logic             write_enable,
    input  logic             reg_index,
    input  logic [CFG_W-1:0] write_data
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PREP = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    state_t           state_reg;
    logic [CFG_W-1:0] period_reg;
    seg_t             seg_len_reg;
    acc_t             acc_reg;
    acc_t             step_reg;
    seg_t             cnt_reg;
    logic             cmd_reg;
    logic             tvalid_reg;
    port_duty_t       tduty_reg;
    logic             began_reg;
    logic             neg_reg;
    logic [MUL_W-1:0] prod_reg;
    logic             out_valid_reg;
    logic [CMP_W-1:0] out_cmp_reg;
    logic             out_began_reg;

    seg_t             seg_eff;
    logic             accept;
    logic             out_free;
    duty_t            acc_clamped;
    duty_t            target;
    acc_t             diff;
    acc_t             diff_mag;
    logic             div_start;
    logic             div_done;
    duty_t            div_quotient;
    acc_t             quo_ext;

    // Zero segment length acts as one
    assign seg_eff     = (seg_len_reg == '0) ? seg_t'(1) : seg_len_reg;
    assign accept      = item.valid && item.ready;
    assign item.ready  = (state_reg == ST_IDLE);
    assign out_free    = !out_valid_reg || result.ready;

    // Step numerator: clamped target minus clamped duty
    assign acc_clamped = clamp_acc(acc_reg);
    assign target      = tvalid_reg ? port_to_duty(tduty_reg) : acc_clamped;
    assign diff        = acc_t'(target) - acc_t'(acc_clamped);
    assign diff_mag    = diff[ACC_W-1] ? -diff : diff;
    assign div_start   = (state_reg == ST_PREP) && began_reg;
    assign quo_ext     = acc_t'(div_quotient);

    pdr_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff_mag[DUTY_W-1:0]),
        .divisor  (seg_eff),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= '1;
            seg_len_reg <= seg_t'(1);
        end
        else if (write_enable)
        begin
            case (reg_index)
                REG_PERIOD:          period_reg  <= write_data;
                REG_SEGMENT_SAMPLES: seg_len_reg <= write_data;
                default:             ;
            endcase
        end
    end

    // Sequencer and ramp state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            step_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (item.command == CMD_START)
                        begin
                            acc_reg  <= acc_t'(port_to_duty(item.initial_duty));
                            step_reg <= '0;
                            cnt_reg  <= '0;
                        end
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    // Clamp duty at segment start, division launched alongside
                    if (began_reg)
                    begin
                        acc_reg   <= acc_t'(acc_clamped);
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        step_reg  <= neg_reg ? -quo_ext : quo_ext;
                        cnt_reg   <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    // Hand over the word, then advance the duty on a tick
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (cmd_reg == CMD_TICK)
                        begin
                            acc_reg <= sat_add(acc_reg, step_reg);
                            if (cnt_reg != '1)
                            begin
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Item capture, sign of numerator, product and output word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= item.command;
            tvalid_reg <= item.target_valid;
            tduty_reg  <= item.target_duty;
            began_reg  <= (item.command == CMD_START) || (cnt_reg >= seg_eff);
        end
        if (state_reg == ST_PREP)
        begin
            neg_reg <= diff[ACC_W-1];
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= acc_clamped * period_reg;
        end
        if ((state_reg == ST_FIN) && out_free)
        begin
            out_cmp_reg   <= prod_reg[DUTY_FRACTION_BITS +: CMP_W];
            out_began_reg <= began_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.compare_value = out_cmp_reg;
    assign result.segment_began = out_began_reg;

    // Block stays busy for the word it has just taken
    `PDR_ASSERT_NEXT(a_busy_after_accept, accept, !item.ready)
    // Divider finishes only while the sequencer waits on it
    `PDR_ASSERT_IMPL(a_div_done_in_wait, div_done, state_reg == ST_DIV)
    // Duty is within 0..1 once a segment has been set up
    `PDR_ASSERT_IMPL(a_acc_clamped, (state_reg == ST_MUL) && began_reg,
                     !acc_reg[ACC_W-1] && (acc_reg <= acc_t'(DUTY_ONE)))

endmodule
